// ===== hdl/esp_pkg.sv =====
// Package for the echo speed estimator: field widths, fixed-point constants
// and window sizing shared by the interfaces, the core and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

  // Field widths.
  localparam int ECHO_W  = 17;
  localparam int GAP_W   = 20;
  localparam int SND_W   = 16;
  localparam int DIST_W  = 15;
  localparam int SPEED_W = 21;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_SPEED = 1'd1;
  localparam logic [GAP_W-1:0] GAP_RESET = 20'd50000;
  localparam logic [SND_W-1:0] SND_RESET = 16'd2248;

  // Averaging window.
  localparam int WINDOW_LEN = 10;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W      = SPEED_W + CNT_W;

  // Fixed-point arithmetic.
  localparam int DPROD_W    = ECHO_W + SND_W;          // echo times sound speed
  localparam int DIST_SHIFT = 13;                      // Q0.16 * 2 / 16
  localparam int DIST_MAX   = 32767;
  localparam int SPEED_K    = 2000000;                 // us per s, times two
  localparam int SPEED_K_W  = 21;
  localparam int SPEED_MAX  = 600000;
  localparam int SMAG_W     = 20;                      // holds SPEED_MAX
  localparam int SPROD_W    = DIST_W + SPEED_K_W;
  localparam int DEN_W      = 22;                      // 2*gap + two echo widths
  localparam int DIVD_W     = SPROD_W + 1;             // numerator plus half divisor
  localparam int ITER_W     = $clog2(DIVD_W + 1);

endpackage : esp_pkg

`default_nettype wire

// ===== hdl/esp_in_if.sv =====
// Input channel of the echo speed estimator: one echo measurement a beat.
// Depends on esp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface esp_in_if;
  logic                      valid;
  logic                      ready;
  logic [esp_pkg::ECHO_W-1:0] echo_us;
  logic                      timed_out;

  modport source (output valid, echo_us, timed_out, input ready);
  modport sink   (input valid, echo_us, timed_out, output ready);
endinterface : esp_in_if

`default_nettype wire

// ===== hdl/esp_out_if.sv =====
// Result channel of the echo speed estimator: mean speed and distance a beat.
// Depends on esp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface esp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [esp_pkg::SPEED_W-1:0] avg_speed;
  logic        [esp_pkg::DIST_W-1:0]  distance;

  modport source (output valid, avg_speed, distance, input ready);
  modport sink   (input valid, avg_speed, distance, output ready);
endinterface : esp_out_if

`default_nettype wire

// ===== hdl/echo_speed_estimator.sv =====
// Echo speed estimator top level: sequencer with two multiply steps
// and one shared restoring divider. Depends on esp_pkg, esp_in_if, esp_out_if.
//
// Usage:
//   in_chan carries one echo width a beat (echo_us, timed_out). A beat with
//   timed_out set is consumed and changes nothing. Any other
//   beat yields a distance; when an earlier nonzero width exists, a speed is
//   pushed into a running-mean window and one beat leaves on out_chan with
//   the mean speed and the current distance.
//   The bit-serial divider runs DIVD_W (37) steps for the speed quotient
//   and SUM_W (25) steps for the mean. A measurement with no earlier
//   nonzero width stops once its distance is stored and yields no result.
//   in_chan.ready is high only while the sequencer is idle, so a new
//   measurement is taken only once the last one has left the sequencer.
//   The finished result sits in an output register, so the next measurement
//   is accepted while the receiver stalls; the sequencer then waits at its
//   final step until the register frees up.
//   Reset (rst_n low, synchronous) empties the window, forgets the previous
//   measurement and restores the register defaults. cfg_we writes register
//   cfg_index from cfg_data. The user must write it only while the block
//   is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module echo_speed_estimator (
  input  wire                            clk,
  input  wire                            rst_n,
  esp_in_if.sink                         in_chan,
  esp_out_if.source                      out_chan,
  input  wire                            cfg_we,
  input  wire [esp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [esp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import esp_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DMUL  = 4'd1;
  localparam logic [3:0] S_DIST  = 4'd2;
  localparam logic [3:0] S_SMUL  = 4'd3;
  localparam logic [3:0] S_SLOAD = 4'd4;
  localparam logic [3:0] S_SDIV  = 4'd5;
  localparam logic [3:0] S_SPUSH = 4'd6;
  localparam logic [3:0] S_SSUM  = 4'd7;
  localparam logic [3:0] S_ALOAD = 4'd8;
  localparam logic [3:0] S_ADIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]               state_r, state_nxt;
  logic [GAP_W-1:0]         gap_r;
  logic [SND_W-1:0]         snd_r;
  logic [ECHO_W-1:0]        echo_r;
  logic [ECHO_W-1:0]        prev_echo_r;
  logic [DIST_W-1:0]        dist_r;
  logic [DIST_W-1:0]        prev_dist_r;
  logic [DPROD_W-1:0]       dprod_r;
  logic [SPROD_W-1:0]       sprod_r;
  logic [DEN_W-1:0]         den_r;
  logic [DEN_W-1:0]         div_r;
  logic [DEN_W-1:0]         rem_r;
  logic [DIVD_W-1:0]        q_r;
  logic [ITER_W-1:0]        iter_r;
  logic                     neg_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic signed [SPEED_W-1:0] old_r;
  logic signed [SPEED_W-1:0] win_r [WINDOW_LEN];
  logic [SLOT_W-1:0]        slot_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     out_valid_r;
  logic signed [SPEED_W-1:0] out_avg_r;
  logic [DIST_W-1:0]        out_dist_r;

  logic                     in_fire;
  logic                     out_free;
  logic                     win_full;
  logic                     div_last;
  logic [DPROD_W:0]         dist_sum;
  logic [DPROD_W-DIST_SHIFT:0] dist_sh;
  logic [DIST_W-1:0]        dist_sat;
  logic signed [DIST_W:0]   diff;
  logic [DIST_W-1:0]        diff_mag;
  logic [DEN_W:0]           rem_sh;
  logic [DEN_W:0]           rem_trial;
  logic                     q_bit;
  logic [SMAG_W-1:0]        smag;
  logic signed [SPEED_W-1:0] speed_val;
  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         sum_num;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign win_full = (cnt_r == CNT_W'(WINDOW_LEN));
  assign div_last = (iter_r == ITER_W'(1));

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.avg_speed = out_avg_r;
  assign out_chan.distance  = out_dist_r;

  // Distance: round the product to 1/16 cm and clamp.
  always_comb begin
    dist_sum = {1'b0, dprod_r} + (DPROD_W + 1)'(1 << (DIST_SHIFT - 1));
    dist_sh  = dist_sum[DPROD_W:DIST_SHIFT];
    dist_sat = (dist_sh > (DPROD_W - DIST_SHIFT + 1)'(DIST_MAX))
               ? DIST_W'(DIST_MAX) : dist_sh[DIST_W-1:0];
  end

  // Distance change since the previous measurement, as sign and magnitude.
  always_comb begin
    diff     = $signed({1'b0, prev_dist_r}) - $signed({1'b0, dist_r});
    diff_mag = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
  end

  // Shared restoring divider step: one quotient bit a cycle.
  always_comb begin
    rem_sh    = {rem_r, q_r[DIVD_W-1]};
    rem_trial = rem_sh - {1'b0, div_r};
    q_bit     = (rem_sh >= {1'b0, div_r});
  end

  // Speed from the quotient magnitude, clamped and signed.
  always_comb begin
    smag      = (q_r > DIVD_W'(SPEED_MAX)) ? SMAG_W'(SPEED_MAX) : q_r[SMAG_W-1:0];
    speed_val = neg_r ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  // Mean numerator: window sum magnitude plus half the fill count.
  always_comb begin
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    sum_num = sum_mag + SUM_W'(cnt_r >> 1);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && !in_chan.timed_out) state_nxt = S_DMUL;
      S_DMUL:  state_nxt = S_DIST;
      S_DIST:  state_nxt = (prev_echo_r != '0) ? S_SMUL : S_IDLE;
      S_SMUL:  state_nxt = S_SLOAD;
      S_SLOAD: state_nxt = S_SDIV;
      S_SDIV:  if (div_last) state_nxt = S_SPUSH;
      S_SPUSH: state_nxt = S_SSUM;
      S_SSUM:  state_nxt = S_ALOAD;
      S_ALOAD: state_nxt = S_ADIV;
      S_ADIV:  if (div_last) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and window bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gap_r       <= GAP_RESET;
      snd_r       <= SND_RESET;
      prev_echo_r <= '0;
      prev_dist_r <= '0;
      slot_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PULSE_GAP:   gap_r <= cfg_data[GAP_W-1:0];
          REG_SOUND_SPEED: snd_r <= cfg_data[SND_W-1:0];
          default: ;
        endcase
      end
      // The output register loads a new beat or empties once it is taken.
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_chan.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_DIST: begin
          if (prev_echo_r == '0) begin
            prev_echo_r <= echo_r;
            prev_dist_r <= dist_sat;
          end
        end
        S_SMUL: begin
          prev_echo_r <= echo_r;
          prev_dist_r <= dist_r;
        end
        S_SPUSH: begin
          if (win_full) sum_r <= sum_r - SUM_W'(old_r);
        end
        S_SSUM: begin
          sum_r  <= sum_r + SUM_W'(speed_r);
          if (!win_full) cnt_r <= cnt_r + CNT_W'(1);
          slot_r <= (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: multiplier, divider and staging.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE:  echo_r  <= in_chan.echo_us;
      S_DMUL:  dprod_r <= DPROD_W'(echo_r) * DPROD_W'(snd_r);
      S_DIST: begin
        dist_r <= dist_sat;
        den_r  <= DEN_W'({gap_r, 1'b0}) + DEN_W'(echo_r) + DEN_W'(prev_echo_r);
      end
      S_SMUL: begin
        sprod_r <= SPROD_W'(diff_mag) * SPROD_W'(SPEED_K);
        neg_r   <= diff[DIST_W];
      end
      S_SLOAD: begin
        q_r    <= DIVD_W'(sprod_r) + DIVD_W'(den_r >> 1);
        div_r  <= den_r;
        rem_r  <= '0;
        iter_r <= ITER_W'(DIVD_W);
      end
      S_SDIV, S_ADIV: begin
        rem_r  <= q_bit ? rem_trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        q_r    <= {q_r[DIVD_W-2:0], q_bit};
        iter_r <= iter_r - ITER_W'(1);
      end
      S_SPUSH: speed_r <= speed_val;
      S_ALOAD: begin
        q_r    <= DIVD_W'(sum_num) << (DIVD_W - SUM_W);
        div_r  <= DEN_W'(cnt_r);
        rem_r  <= '0;
        iter_r <= ITER_W'(SUM_W);
        neg_r  <= sum_r[SUM_W-1];
      end
      S_OUT: begin
        if (out_free) begin
          out_avg_r  <= neg_r ? -$signed(q_r[SPEED_W-1:0]) : $signed(q_r[SPEED_W-1:0]);
          out_dist_r <= dist_r;
        end
      end
      default: ;
    endcase
  end

  // Speed window store: oldest entry read ahead, newest written after it.
  always_ff @(posedge clk) begin
    if (state_r == S_SMUL) old_r <= win_r[slot_r];
    if (state_r == S_SSUM) win_r[slot_r] <= speed_r;
  end

endmodule : echo_speed_estimator

`default_nettype wire

// ===== hdl/esp_checker.sv =====
// Port-level checker for the echo speed estimator, bound to the top level.
// Depends on esp_pkg and on the port names of echo_speed_estimator.
`timescale 1ns / 1ps
`default_nettype none

module esp_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_valid,
  input wire                                 in_ready,
  input wire                                 in_timed_out,
  input wire                                 out_valid,
  input wire                                 out_ready,
  input wire signed [esp_pkg::SPEED_W-1:0]   out_avg_speed,
  input wire        [esp_pkg::DIST_W-1:0]    out_distance
);
  import esp_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_avg_speed) && $stable(out_distance))
    else $error("result payload changed while stalled");

  // A measurement that is not dropped occupies the sequencer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_timed_out |=> !in_ready)
    else $error("input still ready after taking a measurement");

  // A new result only appears after the sequencer has been busy.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without any work done");

  // The mean speed stays within the clamp.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_avg_speed <= SPEED_W'(SPEED_MAX)) &&
                  (out_avg_speed >= -$signed(SPEED_W'(SPEED_MAX))))
    else $error("mean speed out of range");

endmodule : esp_checker

bind echo_speed_estimator esp_checker u_esp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_timed_out  (in_chan.timed_out),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_avg_speed (out_chan.avg_speed),
  .out_distance  (out_chan.distance)
);

`default_nettype wire
